// ===== design/bpbb_pkg.sv =====
// ----------------------------------------------------------------------------
// bpbb_pkg
// Types, constants and helpers shared by the polyline bulge bounding box block.
// ----------------------------------------------------------------------------
package bpbb_pkg;

  localparam int CW         = 32;   // coordinate width
  localparam int BW         = 16;   // bulge width
  localparam int DW         = 33;   // coordinate difference width
  localparam int RW         = 66;   // radicand width
  localparam int EW         = 56;   // doubled centre / extent width
  localparam int QW         = 51;   // quotient width
  localparam int FRAC_SHIFT = 13;
  localparam int CNTW       = 6;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 51;
  localparam logic [31:0] B2_ONE = 32'h0100_0000;

  typedef struct packed {
    logic signed [CW-1:0] vertex_x;
    logic signed [CW-1:0] vertex_y;
    logic signed [BW-1:0] bulge;
    logic                 last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_max_y;
  } box_t;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_POINT  = 12'b0000_0000_0010,
    ST_SEG    = 12'b0000_0000_0100,
    ST_MUL_LO = 12'b0000_0000_1000,
    ST_MUL_HI = 12'b0000_0001_0000,
    ST_STORE  = 12'b0000_0010_0000,
    ST_SQRT   = 12'b0000_0100_0000,
    ST_DIV    = 12'b0000_1000_0000,
    ST_QWB    = 12'b0001_0000_0000,
    ST_APPLY  = 12'b0010_0000_0000,
    ST_UPDATE = 12'b0100_0000_0000,
    ST_OUT    = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_POINT,
    OP_SEG,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_STORE,
    OP_SQRT,
    OP_DIV,
    OP_QWB,
    OP_APPLY,
    OP_UPDATE,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    P_SX,
    P_SY,
    P_B2,
    P_THR,
    P_DYN,
    P_DXN,
    P_DYM,
    P_DXM,
    P_CN
  } prod_e;

  typedef struct packed {
    op_e   op;
    prod_e prod;
    logic  seg_close;
    logic  have_prior;
  } cmd_t;

  typedef struct packed {
    logic arc_ok;
    logic last_vertex;
  } status_t;

  function automatic logic signed [CW-1:0] sat32(logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = $signed({{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    lo = $signed({{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}});
    if (v > hi) begin
      return hi[CW-1:0];
    end else if (v < lo) begin
      return lo[CW-1:0];
    end else begin
      return v[CW-1:0];
    end
  endfunction

endpackage

// ===== design/bpbb_dp.sv =====
// ----------------------------------------------------------------------------
// bpbb_dp
// Datapath: vertex and box registers, shared split multiplier, bit-serial
// square root and restoring divider, arc extent merge.
// ----------------------------------------------------------------------------
module bpbb_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpbb_pkg::vertex_t in_data_i,
  input  bpbb_pkg::cmd_t    cmd_i,
  output bpbb_pkg::status_t sts_o,
  output bpbb_pkg::box_t    out_data_o
);

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;

  bpbb_pkg::vertex_t cur_q;
  bpbb_pkg::box_t    box_q;
  bpbb_pkg::box_t    out_q;

  logic signed [31:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [15:0] prev_b_q;

  logic signed [32:0] sum_x_q, sum_y_q, dx_q, dy_q;
  logic               bneg_q;
  logic [15:0]        absb_q;
  logic [63:0]        acc_q, sx_q;
  logic [65:0]        rad_q;
  logic [35:0]        sq_rem_q;
  logic [32:0]        root_q;
  logic [30:0]        n_q;
  logic signed [31:0] m_q;
  logic signed [65:0] thr_q;
  logic [3:0]         flag_q;     // {+x, +y, -x, -y}
  logic [50:0]        dq_q;
  logic [15:0]        drem_q;
  logic signed [55:0] cx2_q, cy2_q;
  logic [50:0]        r2_q;

  // segment setup
  logic signed [31:0] seg_x2, seg_y2;
  logic signed [32:0] dx_d, dy_d;
  assign seg_x2 = cmd_i.seg_close ? first_x_q : cur_q.vertex_x;
  assign seg_y2 = cmd_i.seg_close ? first_y_q : cur_q.vertex_y;
  assign dx_d   = {seg_x2[31], seg_x2} - {prev_x_q[31], prev_x_q};
  assign dy_d   = {seg_y2[31], seg_y2} - {prev_y_q[31], prev_y_q};

  assign sts_o.arc_ok      = (prev_b_q != 16'sd0) && ((dx_d != 33'sd0) || (dy_d != 33'sd0));
  assign sts_o.last_vertex = cur_q.last_vertex;

  // magnitudes
  logic [32:0] dx_neg, dy_neg;
  logic [31:0] ax, ay, m_abs;
  logic        m_neg;
  assign dx_neg = -dx_q;
  assign dy_neg = -dy_q;
  assign ax     = dx_q[32] ? dx_neg[31:0] : dx_q[31:0];
  assign ay     = dy_q[32] ? dy_neg[31:0] : dy_q[31:0];
  assign m_neg  = m_q[31];
  assign m_abs  = m_neg ? 32'(-m_q) : 32'(m_q);

  // multiplier operands
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  always_comb begin
    case (cmd_i.prod)
      bpbb_pkg::P_SX:  begin mul_a = {1'b0, ax};          mul_b = ax;            end
      bpbb_pkg::P_SY:  begin mul_a = {1'b0, ay};          mul_b = ay;            end
      bpbb_pkg::P_B2:  begin mul_a = {17'd0, absb_q};     mul_b = {16'd0, absb_q}; end
      bpbb_pkg::P_THR: begin mul_a = root_q;              mul_b = m_abs;         end
      bpbb_pkg::P_DYN: begin mul_a = {1'b0, ay};          mul_b = {1'b0, n_q};   end
      bpbb_pkg::P_DXN: begin mul_a = {1'b0, ax};          mul_b = {1'b0, n_q};   end
      bpbb_pkg::P_DYM: begin mul_a = {1'b0, ay};          mul_b = m_abs;         end
      bpbb_pkg::P_DXM: begin mul_a = {1'b0, ax};          mul_b = m_abs;         end
      bpbb_pkg::P_CN:  begin mul_a = root_q;              mul_b = {1'b0, n_q};   end
      default:         begin mul_a = '0;                  mul_b = '0;            end
    endcase
  end

  logic [47:0] lo_prod;
  logic [48:0] hi_prod;
  assign lo_prod = mul_a[15:0] * mul_b;
  assign hi_prod = mul_a[32:16] * mul_b;

  // signed views of the product
  logic signed [65:0] prod_s, prod_n, v_dy, v_dx, v_dy_n, v_dx_n;
  assign prod_s = $signed({2'b00, acc_q});
  assign prod_n = -prod_s;
  assign v_dy   = (dy_q[32] ^ bneg_q) ? prod_n : prod_s;
  assign v_dx   = (dx_q[32] ^ bneg_q) ? prod_n : prod_s;
  assign v_dy_n = -v_dy;
  assign v_dx_n = -v_dx;

  // square root step
  logic [35:0] sq_rem_t;
  logic [32:0] root_sh;
  logic [35:0] sq_trial;
  assign sq_rem_t = {sq_rem_q[33:0], rad_q[65:64]};
  assign root_sh  = {root_q[31:0], 1'b0};
  assign sq_trial = {2'b00, root_sh, 1'b1};

  // divider step
  logic [16:0] dv_trial;
  assign dv_trial = {drem_q, dq_q[50]};

  // quotient with sign
  logic signed [55:0] q_s, q_y, q_x;
  assign q_s = $signed({5'd0, dq_q});
  assign q_y = (dy_q[32] ^ m_neg ^ bneg_q) ? -q_s : q_s;
  assign q_x = (dx_q[32] ^ m_neg ^ bneg_q) ? -q_s : q_s;

  // extents
  logic signed [55:0] r2_s, e_px, e_nx, e_py, e_ny;
  logic signed [31:0] s_px, s_nx, s_py, s_ny;
  assign r2_s = $signed({5'd0, r2_q});
  assign e_px = (cx2_q + r2_s) >>> 1;
  assign e_nx = (cx2_q - r2_s) >>> 1;
  assign e_py = (cy2_q + r2_s) >>> 1;
  assign e_ny = (cy2_q - r2_s) >>> 1;
  assign s_px = bpbb_pkg::sat32(e_px);
  assign s_nx = bpbb_pkg::sat32(e_nx);
  assign s_py = bpbb_pkg::sat32(e_py);
  assign s_ny = bpbb_pkg::sat32(e_ny);

  logic [64:0] sq_sum;
  assign sq_sum = {1'b0, sx_q} + {1'b0, acc_q};

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q     <= '{POS_MAX, NEG_MAX, POS_MAX, NEG_MAX};
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      prev_b_q  <= '0;
    end else begin
      case (cmd_i.op)
        bpbb_pkg::OP_POINT: begin
          if (cur_q.vertex_x < box_q.box_min_x) box_q.box_min_x <= cur_q.vertex_x;
          if (cur_q.vertex_x > box_q.box_max_x) box_q.box_max_x <= cur_q.vertex_x;
          if (cur_q.vertex_y < box_q.box_min_y) box_q.box_min_y <= cur_q.vertex_y;
          if (cur_q.vertex_y > box_q.box_max_y) box_q.box_max_y <= cur_q.vertex_y;
          if (!cmd_i.have_prior) begin
            first_x_q <= cur_q.vertex_x;
            first_y_q <= cur_q.vertex_y;
          end
        end
        bpbb_pkg::OP_APPLY: begin
          if (flag_q[3] && (s_px > box_q.box_max_x)) box_q.box_max_x <= s_px;
          if (flag_q[2] && (s_py > box_q.box_max_y)) box_q.box_max_y <= s_py;
          if (flag_q[1] && (s_nx < box_q.box_min_x)) box_q.box_min_x <= s_nx;
          if (flag_q[0] && (s_ny < box_q.box_min_y)) box_q.box_min_y <= s_ny;
        end
        bpbb_pkg::OP_UPDATE: begin
          prev_x_q <= cur_q.vertex_x;
          prev_y_q <= cur_q.vertex_y;
          prev_b_q <= cur_q.bulge;
        end
        bpbb_pkg::OP_OUT: begin
          box_q <= '{POS_MAX, NEG_MAX, POS_MAX, NEG_MAX};
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bpbb_pkg::OP_LOAD: cur_q <= in_data_i;
      bpbb_pkg::OP_SEG: begin
        sum_x_q <= {prev_x_q[31], prev_x_q} + {seg_x2[31], seg_x2};
        sum_y_q <= {prev_y_q[31], prev_y_q} + {seg_y2[31], seg_y2};
        dx_q    <= dx_d;
        dy_q    <= dy_d;
        bneg_q  <= prev_b_q[15];
        absb_q  <= prev_b_q[15] ? 16'(-prev_b_q) : 16'(prev_b_q);
      end
      bpbb_pkg::OP_MUL_LO: acc_q <= {16'd0, lo_prod};
      bpbb_pkg::OP_MUL_HI: acc_q <= acc_q + {hi_prod[47:0], 16'd0};
      bpbb_pkg::OP_STORE: begin
        case (cmd_i.prod)
          bpbb_pkg::P_SX: sx_q <= acc_q;
          bpbb_pkg::P_SY: begin
            rad_q    <= {1'b0, sq_sum};
            sq_rem_q <= '0;
            root_q   <= '0;
          end
          bpbb_pkg::P_B2: begin
            n_q <= bpbb_pkg::B2_ONE[30:0] + acc_q[30:0];
            m_q <= $signed(bpbb_pkg::B2_ONE - {1'b0, acc_q[30:0]});
          end
          bpbb_pkg::P_THR: thr_q <= m_neg ? prod_n : prod_s;
          bpbb_pkg::P_DYN: begin
            flag_q[3] <= v_dy > thr_q;
            flag_q[1] <= v_dy_n > thr_q;
          end
          bpbb_pkg::P_DXN: begin
            flag_q[0] <= v_dx > thr_q;
            flag_q[2] <= v_dx_n > thr_q;
          end
          bpbb_pkg::P_DYM, bpbb_pkg::P_DXM, bpbb_pkg::P_CN: begin
            dq_q   <= acc_q[63:bpbb_pkg::FRAC_SHIFT];
            drem_q <= '0;
          end
          default: ;
        endcase
      end
      bpbb_pkg::OP_SQRT: begin
        rad_q <= {rad_q[63:0], 2'b00};
        if (sq_rem_t >= sq_trial) begin
          sq_rem_q <= sq_rem_t - sq_trial;
          root_q   <= root_sh | 33'd1;
        end else begin
          sq_rem_q <= sq_rem_t;
          root_q   <= root_sh;
        end
      end
      bpbb_pkg::OP_DIV: begin
        if (dv_trial >= {1'b0, absb_q}) begin
          drem_q <= 16'(dv_trial - {1'b0, absb_q});
          dq_q   <= {dq_q[49:0], 1'b1};
        end else begin
          drem_q <= dv_trial[15:0];
          dq_q   <= {dq_q[49:0], 1'b0};
        end
      end
      bpbb_pkg::OP_QWB: begin
        case (cmd_i.prod)
          bpbb_pkg::P_DYM: cx2_q <= $signed({{23{sum_x_q[32]}}, sum_x_q}) - q_y;
          bpbb_pkg::P_DXM: cy2_q <= $signed({{23{sum_y_q[32]}}, sum_y_q}) + q_x;
          bpbb_pkg::P_CN:  r2_q  <= dq_q;
          default: ;
        endcase
      end
      bpbb_pkg::OP_OUT: out_q <= box_q;
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

// ===== design/bpbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpbb_ctrl
// Controller: handshakes, configuration register and the sequencer that walks
// the datapath through point merge, arc setup, products, root and quotients.
// ----------------------------------------------------------------------------
module bpbb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  bpbb_pkg::status_t sts_i,
  output bpbb_pkg::cmd_t    cmd_o
);

  bpbb_pkg::state_e state_q, state_d;
  bpbb_pkg::prod_e  prod_q, prod_d;
  logic [bpbb_pkg::CNTW-1:0] cnt_q, cnt_d;
  logic close_q, close_d;
  logic have_prior_q, have_prior_d;
  logic closed_q;
  logic out_valid_q, out_valid_d;
  logic out_free;
  bpbb_pkg::state_e ret_state;

  assign in_ready_o  = (state_q == bpbb_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign ret_state   = close_q ? bpbb_pkg::ST_OUT : bpbb_pkg::ST_UPDATE;

  always_comb begin
    state_d      = state_q;
    prod_d       = prod_q;
    cnt_d        = cnt_q;
    close_d      = close_q;
    have_prior_d = have_prior_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.op         = bpbb_pkg::OP_NONE;
    cmd_o.prod       = prod_q;
    cmd_o.seg_close  = close_q;
    cmd_o.have_prior = have_prior_q;

    case (state_q)
      bpbb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = bpbb_pkg::OP_LOAD;
          state_d  = bpbb_pkg::ST_POINT;
        end
      end
      bpbb_pkg::ST_POINT: begin
        cmd_o.op = bpbb_pkg::OP_POINT;
        close_d  = 1'b0;
        state_d  = have_prior_q ? bpbb_pkg::ST_SEG : bpbb_pkg::ST_UPDATE;
      end
      bpbb_pkg::ST_SEG: begin
        cmd_o.op = bpbb_pkg::OP_SEG;
        if (sts_i.arc_ok) begin
          prod_d  = bpbb_pkg::P_SX;
          state_d = bpbb_pkg::ST_MUL_LO;
        end else begin
          state_d = ret_state;
        end
      end
      bpbb_pkg::ST_MUL_LO: begin
        cmd_o.op = bpbb_pkg::OP_MUL_LO;
        state_d  = bpbb_pkg::ST_MUL_HI;
      end
      bpbb_pkg::ST_MUL_HI: begin
        cmd_o.op = bpbb_pkg::OP_MUL_HI;
        state_d  = bpbb_pkg::ST_STORE;
      end
      bpbb_pkg::ST_STORE: begin
        cmd_o.op = bpbb_pkg::OP_STORE;
        state_d  = bpbb_pkg::ST_MUL_LO;
        case (prod_q)
          bpbb_pkg::P_SX:  prod_d = bpbb_pkg::P_SY;
          bpbb_pkg::P_SY:  prod_d = bpbb_pkg::P_B2;
          bpbb_pkg::P_B2: begin
            cnt_d   = bpbb_pkg::CNTW'(bpbb_pkg::SQRT_STEPS - 1);
            state_d = bpbb_pkg::ST_SQRT;
          end
          bpbb_pkg::P_THR: prod_d = bpbb_pkg::P_DYN;
          bpbb_pkg::P_DYN: prod_d = bpbb_pkg::P_DXN;
          bpbb_pkg::P_DXN: prod_d = bpbb_pkg::P_DYM;
          bpbb_pkg::P_DYM, bpbb_pkg::P_DXM, bpbb_pkg::P_CN: begin
            cnt_d   = bpbb_pkg::CNTW'(bpbb_pkg::DIV_STEPS - 1);
            state_d = bpbb_pkg::ST_DIV;
          end
          default: state_d = ret_state;
        endcase
      end
      bpbb_pkg::ST_SQRT: begin
        cmd_o.op = bpbb_pkg::OP_SQRT;
        if (cnt_q == '0) begin
          prod_d  = bpbb_pkg::P_THR;
          state_d = bpbb_pkg::ST_MUL_LO;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      bpbb_pkg::ST_DIV: begin
        cmd_o.op = bpbb_pkg::OP_DIV;
        if (cnt_q == '0) begin
          state_d = bpbb_pkg::ST_QWB;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      bpbb_pkg::ST_QWB: begin
        cmd_o.op = bpbb_pkg::OP_QWB;
        case (prod_q)
          bpbb_pkg::P_DYM: begin
            prod_d  = bpbb_pkg::P_DXM;
            state_d = bpbb_pkg::ST_MUL_LO;
          end
          bpbb_pkg::P_DXM: begin
            prod_d  = bpbb_pkg::P_CN;
            state_d = bpbb_pkg::ST_MUL_LO;
          end
          default: state_d = bpbb_pkg::ST_APPLY;
        endcase
      end
      bpbb_pkg::ST_APPLY: begin
        cmd_o.op = bpbb_pkg::OP_APPLY;
        state_d  = ret_state;
      end
      bpbb_pkg::ST_UPDATE: begin
        cmd_o.op     = bpbb_pkg::OP_UPDATE;
        have_prior_d = 1'b1;
        if (!sts_i.last_vertex) begin
          state_d = bpbb_pkg::ST_IDLE;
        end else if (closed_q) begin
          close_d = 1'b1;
          state_d = bpbb_pkg::ST_SEG;
        end else begin
          state_d = bpbb_pkg::ST_OUT;
        end
      end
      bpbb_pkg::ST_OUT: begin
        if (out_free) begin
          cmd_o.op     = bpbb_pkg::OP_OUT;
          out_valid_d  = 1'b1;
          have_prior_d = 1'b0;
          state_d      = bpbb_pkg::ST_IDLE;
        end
      end
      default: state_d = bpbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpbb_pkg::ST_IDLE;
      prod_q       <= bpbb_pkg::P_SX;
      cnt_q        <= '0;
      close_q      <= 1'b0;
      have_prior_q <= 1'b0;
      closed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prod_q       <= prod_d;
      cnt_q        <= cnt_d;
      close_q      <= close_d;
      have_prior_q <= have_prior_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) closed_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== design/bulge_polyline_bounding_box_top.sv =====
// ----------------------------------------------------------------------------
// bulge_polyline_bounding_box_top
// Running bounding box of a polyline with bulge arcs, one request per vertex.
// ----------------------------------------------------------------------------
// Vertex with no arc: load, point merge, segment check, update; a first vertex skips the segment check.
// Arc segment adds nine products (low half, high half, store) on one shared split multiplier,
//   a 33-step square root, three divisions (51 steps plus write-back), one merge.
// Last vertex: an output step, plus a closing segment check and arc when closed; the output
//   step waits only while an earlier box is still held, the next vertex may enter after it.
// Reset: box empty, no vertex held, closed_flag cleared; no output pending.
module bulge_polyline_bounding_box_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpbb_pkg::vertex_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpbb_pkg::box_t    out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  bpbb_pkg::cmd_t    cmd;
  bpbb_pkg::status_t sts;

  bpbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpbb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/bpbb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpbb_checker
// Watches the vertex and box channels of the bulge bounding box block, keeps
// its own running box and arc math, and compares every box against the queue.
// ----------------------------------------------------------------------------
module bpbb_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bpbb_pkg::vertex_t in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bpbb_pkg::box_t    out_data_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;

  logic              closed_q;
  logic signed [31:0] first_x, first_y, prior_x, prior_y;
  logic signed [15:0] prior_b;
  logic              have_prior;
  bpbb_pkg::box_t    box_acc;
  bpbb_pkg::box_t    box_q[$];
  int                fails;
  int                pend;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return POS_MAX;
    if (v < -128'sh8000_0000) return NEG_MAX;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] floor_half(logic signed [127:0] v);
    return v >>> 1;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [127:0] r, b;
    r = 0;
    for (int i = 33; i >= 0; i--) begin
      b = r | (128'd1 << i);
      if (b * b <= v) r = b;
    end
    return r[63:0];
  endfunction

  task automatic merge_arc(input logic signed [31:0] x1, y1, x2, y2,
                           input logic signed [15:0] bg);
    logic signed [127:0] dx, dy, bb, n, m, s, thr, c, cx2, cy2, r2, div;
    logic signed [127:0] ax, ay;
    logic signed [31:0]  e;
    dx = x2 - x1;
    dy = y2 - y1;
    bb = bg;
    if (bb == 0 || (dx == 0 && dy == 0)) return;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    c  = isqrt(ax * ax + ay * ay);
    n  = 128'sd16777216 + bb * bb;
    m  = 128'sd16777216 - bb * bb;
    s  = bb > 0 ? 1 : -1;
    thr = c * m;
    div = bb * 8192;
    cx2 = x1 + x2 - (dy * m) / div;
    cy2 = y1 + y2 + (dx * m) / div;
    r2  = (c * n) / ((bb < 0 ? -bb : bb) * 8192);
    if (s * dy * n > thr) begin
      e = clamp32(floor_half(cx2 + r2));
      if (e > box_acc.box_max_x) box_acc.box_max_x = e;
    end
    if (-s * dx * n > thr) begin
      e = clamp32(floor_half(cy2 + r2));
      if (e > box_acc.box_max_y) box_acc.box_max_y = e;
    end
    if (-s * dy * n > thr) begin
      e = clamp32(floor_half(cx2 - r2));
      if (e < box_acc.box_min_x) box_acc.box_min_x = e;
    end
    if (s * dx * n > thr) begin
      e = clamp32(floor_half(cy2 - r2));
      if (e < box_acc.box_min_y) box_acc.box_min_y = e;
    end
  endtask

  task automatic take_vertex(input bpbb_pkg::vertex_t v);
    if (have_prior) begin
      merge_arc(prior_x, prior_y, v.vertex_x, v.vertex_y, prior_b);
    end else begin
      first_x = v.vertex_x;
      first_y = v.vertex_y;
    end
    if (v.vertex_x < box_acc.box_min_x) box_acc.box_min_x = v.vertex_x;
    if (v.vertex_x > box_acc.box_max_x) box_acc.box_max_x = v.vertex_x;
    if (v.vertex_y < box_acc.box_min_y) box_acc.box_min_y = v.vertex_y;
    if (v.vertex_y > box_acc.box_max_y) box_acc.box_max_y = v.vertex_y;
    prior_x = v.vertex_x;
    prior_y = v.vertex_y;
    prior_b = v.bulge;
    have_prior = 1'b1;
    if (v.last_vertex) begin
      if (closed_q) merge_arc(v.vertex_x, v.vertex_y, first_x, first_y, v.bulge);
      box_q.push_back(box_acc);
      have_prior = 1'b0;
      box_acc = '{POS_MAX, NEG_MAX, POS_MAX, NEG_MAX};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bpbb_pkg::box_t want;
    if (!rst_ni) begin
      closed_q   = 1'b0;
      first_x    = '0;
      first_y    = '0;
      prior_x    = '0;
      prior_y    = '0;
      prior_b    = '0;
      have_prior = 1'b0;
      box_acc    = '{POS_MAX, NEG_MAX, POS_MAX, NEG_MAX};
      box_q.delete();
      fails      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (box_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected box %h", out_data_i);
        end else begin
          want = box_q.pop_front();
          if (want !== out_data_i) begin
            fails++;
            if (fails <= 10) $display(
              "box mismatch exp min_x %0d max_x %0d min_y %0d max_y %0d got %0d %0d %0d %0d",
              want.box_min_x, want.box_max_x, want.box_min_y, want.box_max_y,
              out_data_i.box_min_x, out_data_i.box_max_x,
              out_data_i.box_min_y, out_data_i.box_max_y);
          end
        end
      end
      if (in_valid_i && in_ready_i) take_vertex(in_data_i);
      if (cfg_we_i) closed_q = cfg_wdata_i;
    end
    pend = box_q.size();
  end

endmodule

// ===== tb/tb_bulge_polyline_bounding_box_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bulge_polyline_bounding_box_top
// Drives polylines of straight and arc segments through the bounding box
// block with random stalls on both channels, in open and closed mode.
// ----------------------------------------------------------------------------
module tb_bulge_polyline_bounding_box_top;

  localparam longint CYCLE_LIMIT = 64'd4_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  bpbb_pkg::vertex_t in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  bpbb_pkg::box_t    out_data_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  int                fail_count, pending;
  int                send_idle, recv_idle;
  longint            cycles = 0;

  always #10 clk_i = ~clk_i;

  bulge_polyline_bounding_box_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  bpbb_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[bulge_polyline_bounding_box_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(8191)) - 4096;
      default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_bulge();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'($urandom);
      2: return 16'sh7FFF;
      3: return 16'sh8000;
      default: return 16'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  task automatic send(input logic signed [31:0] x, y, input logic signed [15:0] b,
                      input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{x, y, b, last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_and_set(input logic closed);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= closed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_polylines(input int count);
    int len, mode;
    for (int i = 0; i < count; i += len) begin
      len  = $urandom_range(6, 1);
      mode = $urandom_range(2);
      for (int k = 0; k < len; k++)
        send(rand_coord(mode), rand_coord(mode), rand_bulge(), k == len - 1);
    end
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drain_and_set(1'b0);
    send(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 1'b1);
    send(0, 0, 16'sh1000, 1'b0);
    send(32'sh0001_0000, 0, 16'sh8000, 1'b0);
    send(32'sh0001_0000, 0, 16'sh1000, 1'b0);
    send(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh0800, 1'b0);
    send(32'sh7FFF_FFFF, 32'sh8000_0000, 16'shF800, 1'b1);
    drain_and_set(1'b1);
    send(5, 7, 16'sh1000, 1'b1);
    send(0, 0, 16'sh1000, 1'b0);
    send(32'sh0002_0000, 0, 16'shF000, 1'b0);
    send(32'sh0002_0000, 32'sh0002_0000, 16'sh7FFF, 1'b1);
    send(32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 1'b0);
    send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh0001, 1'b1);
    send(-100, 100, 16'shFFFF, 1'b0);
    send(100, -100, 16'sh0000, 1'b1);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 85; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 85; end
        default: begin send_idle = 24; recv_idle = 24; end
      endcase
      random_polylines(225);
      drain_and_set(ph[0]);
    end
    if (fail_count == 0) begin
      $display("[bulge_polyline_bounding_box_top] OK");
    end else begin
      $display("[bulge_polyline_bounding_box_top] ERROR");
    end
    $finish;
  end

endmodule
